/* rtl/tcf_pkg.sv */
// Shared types, constants and helper functions for the tilt complementary filter.
package tcf_pkg;

  // CORDIC iteration count; the arctangent table covers up to 20 steps.
  localparam int CORDIC_STEPS = 14;
  localparam int ATAN_N       = 20;
  localparam int ATAN_IDX_W   = 5;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // Vector registers hold input * 2^16 plus CORDIC growth.
  localparam int VEC_W = 36;
  // Angle accumulator in units of 2^-24 rad.
  localparam int ACC_W = 28;
  localparam logic signed [ACC_W-1:0] PI_UNITS = 28'sd52707179;
  localparam logic signed [ACC_W-1:0] MEAS_BIAS = 28'sd1024;
  localparam int MEAS_SHIFT = 11;

  // Blend datapath widths.
  localparam int RD_W   = 33;
  localparam int WM_W   = 34;
  localparam int AP_W   = 50;
  localparam int SUM_W  = 51;
  localparam int BLEND_SHIFT = 29;
  localparam int SAT_IN_W = SUM_W - BLEND_SHIFT;

  // Job queue depth between front and back.
  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET  = 2'd2;

  localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd64225;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd1311;
  localparam logic signed [15:0] ANGLE_OFFSET_RST = 16'sd1679;

  // Input vector class decided by the front end.
  typedef enum logic [1:0] {
    QUAD_RIGHT   = 2'd0,
    QUAD_LEFT_UP = 2'd1,
    QUAD_LEFT_DN = 2'd2,
    QUAD_ZERO    = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [16:0] vx0;
    logic signed [16:0] vy0;
    quad_t              quad;
    logic signed [15:0] rate;
  } tcf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tcf_qstat_t;

  typedef struct packed {
    logic [15:0]        blend_weight;
    logic [15:0]        sample_period;
    logic signed [15:0] angle_offset;
  } tcf_cfg_t;

  // Arctangent of 2^-i in units of 2^-24 rad, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    unique case (i)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_IN_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -SAT_IN_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tcf_if.sv */
// Valid/ready stream interfaces for IMU samples and pitch results.
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_y;

  modport source (output valid, output accel_x, output accel_z, output rate_y, input ready);
  modport sink   (input valid, input accel_x, input accel_z, input rate_y, output ready);
endinterface

interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_angle;
  logic signed [15:0] filtered_angle;

  modport source (output valid, output measured_angle, output filtered_angle, input ready);
  modport sink   (input valid, input measured_angle, input filtered_angle, output ready);
endinterface

/* rtl/tcf_front.sv */
// Front end: accepts IMU samples, folds the vector into the right half plane, classifies it.
module tcf_front
  import tcf_pkg::*;
(
  tcf_in_if.sink     in_chan,
  input  tcf_qstat_t qstat,
  output logic       push,
  output tcf_job_t   job
);

  logic x_neg;
  logic z_neg;
  logic is_zero;
  logic signed [16:0] x_ext;
  logic signed [16:0] z_ext;

  assign in_chan.ready = !qstat.full;
  assign push          = in_chan.valid && in_chan.ready;

  assign x_ext   = 17'(in_chan.accel_x);
  assign z_ext   = 17'(in_chan.accel_z);
  assign x_neg   = in_chan.accel_x[15];
  assign z_neg   = in_chan.accel_z[15];
  assign is_zero = (in_chan.accel_x == '0) && (in_chan.accel_z == '0);

  always_comb begin
    // turn left-half vectors by pi
    job.vx0  = x_neg ? -x_ext : x_ext;
    job.vy0  = x_neg ? -z_ext : z_ext;
    job.rate = in_chan.rate_y;
    priority if (is_zero) begin
      job.quad = QUAD_ZERO;
    end else if (x_neg && !z_neg) begin
      job.quad = QUAD_LEFT_UP;
    end else if (x_neg) begin
      job.quad = QUAD_LEFT_DN;
    end else begin
      job.quad = QUAD_RIGHT;
    end
  end

endmodule

/* rtl/tcf_queue.sv */
// Short job queue that decouples the front end from the compute back end.
module tcf_queue
  import tcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tcf_job_t   job_in,
  input  logic       pop,
  output tcf_job_t   job_out,
  output tcf_qstat_t qstat
);

  tcf_job_t         slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign job_out     = slot_r[rd_ptr_r];
  assign qstat.full  = (count_r == CNT_W'(Q_DEPTH));
  assign qstat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

/* rtl/tcf_back.sv */
// Back end: iterative CORDIC atan2, offset removal, complementary blend and result register.
module tcf_back
  import tcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tcf_cfg_t   cfg,
  input  tcf_qstat_t qstat,
  input  tcf_job_t   job_in,
  output logic       pop,
  tcf_out_if.source  out_chan
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ITER = 6'b000010,
    S_MEAS = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;

  logic [STEP_W-1:0]       step_r;
  logic signed [VEC_W-1:0] vx_r;
  logic signed [VEC_W-1:0] vy_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    zero_r;
  logic signed [15:0]      rate_r;
  logic signed [15:0]      meas_q_r;
  logic signed [31:0]      rd_r;
  logic signed [WM_W-1:0]  wm_r;
  logic signed [WM_W-1:0]  ae_r;
  logic signed [AP_W-1:0]  ap_r;
  logic signed [15:0]      est_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [15:0]      out_meas_r;
  logic signed [15:0]      out_filt_r;

  logic                    out_free;
  logic                    retire;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  logic signed [ACC_W-1:0] step_ang;
  logic signed [ACC_W-1:0] ang_biased;
  logic signed [SAT_IN_W-1:0] meas_diff;
  logic [16:0]             gyro_w;
  logic [16:0]             accel_w;
  logic signed [RD_W-1:0]  rd_prod;
  logic signed [WM_W-1:0]  wm_prod;
  logic signed [WM_W-1:0]  ae_prod;
  logic signed [AP_W-1:0]  ap_prod;
  logic signed [SUM_W-1:0] blend_sum;
  logic signed [15:0]      filt;
  logic signed [ACC_W-1:0] acc_start;

  assign out_free = !out_valid_r || out_chan.ready;
  assign retire   = (state_r == S_SUM) && out_free;
  assign pop      = (state_r == S_IDLE) && !qstat.empty;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.measured_angle = out_meas_r;
  assign out_chan.filtered_angle = out_filt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!qstat.empty) state_nxt = S_ITER;
      S_ITER: if (step_r == STEP_LAST) state_nxt = S_MEAS;
      S_MEAS: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SUM;
      S_SUM:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (job_in.quad)
      QUAD_LEFT_UP: acc_start = PI_UNITS;
      QUAD_LEFT_DN: acc_start = -PI_UNITS;
      default:      acc_start = '0;
    endcase
  end

  // CORDIC step datapath
  assign dx       = vy_r >>> step_r;
  assign dy       = vx_r >>> step_r;
  assign step_ang = atan_entry(ATAN_IDX_W'(step_r));

  // Round to Q2.13 and remove the mounting offset
  assign ang_biased = (zero_r ? '0 : acc_r) + MEAS_BIAS;
  assign meas_diff  = SAT_IN_W'(signed'(ang_biased[ACC_W-1:MEAS_SHIFT]))
                    - SAT_IN_W'(cfg.angle_offset);

  // Blend products
  assign gyro_w  = {1'b0, cfg.blend_weight};
  assign accel_w = 17'h10000 - gyro_w;
  assign rd_prod = RD_W'(rate_r) * RD_W'(signed'({1'b0, cfg.sample_period}));
  assign wm_prod = WM_W'(signed'({1'b0, accel_w})) * WM_W'(meas_q_r);
  assign ae_prod = WM_W'(signed'({1'b0, gyro_w})) * WM_W'(est_r);
  assign ap_prod = AP_W'(signed'({1'b0, gyro_w})) * AP_W'(rd_r);

  assign blend_sum = ((SUM_W'(wm_r) + SUM_W'(ae_r)) <<< 13) + SUM_W'(ap_r)
                   + (SUM_W'(1) <<< (BLEND_SHIFT - 1));
  assign filt      = sat16(blend_sum[SUM_W-1:BLEND_SHIFT]);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (retire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      est_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (retire) begin
        est_r <= filt;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          vx_r   <= VEC_W'(job_in.vx0) <<< 16;
          vy_r   <= VEC_W'(job_in.vy0) <<< 16;
          acc_r  <= acc_start;
          zero_r <= (job_in.quad == QUAD_ZERO);
          rate_r <= job_in.rate;
          step_r <= '0;
        end
      end
      S_ITER: begin
        if (!vy_r[VEC_W-1]) begin
          vx_r  <= vx_r + dx;
          vy_r  <= vy_r - dy;
          acc_r <= acc_r + step_ang;
        end else begin
          vx_r  <= vx_r - dx;
          vy_r  <= vy_r + dy;
          acc_r <= acc_r - step_ang;
        end
        step_r <= step_r + 1'b1;
      end
      S_MEAS: meas_q_r <= sat16(meas_diff);
      S_MUL1: begin
        rd_r <= rd_prod[31:0];
        wm_r <= wm_prod;
        ae_r <= ae_prod;
      end
      S_MUL2: ap_r <= ap_prod;
      S_SUM: begin
        if (retire) begin
          out_meas_r <= meas_q_r;
          out_filt_r <= filt;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/tilt_complementary_filter.sv */
// Top level of the tilt complementary filter: config registers, front end, job queue, back end.
//
// Usage:
//   in_chan  : one IMU sample per request (accel_x, accel_z raw counts, rate_y Q5.10 rad/s).
//   out_chan : one result per sample (measured_angle, filtered_angle, Q2.13 rad).
//   cfg_*    : plain write port; index 0 blend weight, 1 sample period, 2 angle offset.
//              Write only while no sample is in flight; other indexes are dropped.
// Path: a sample accepted into an empty block passes the queue, the CORDIC iterations, the
//   rounding step, the two multiply steps and the sum before it shows on out_chan.
// Pacing: the back end takes one sample at a time, the next only once the last has retired;
//   its iterative CORDIC retires one rotation per cycle, then its rounding and blend steps run.
// The front end takes requests into a two-entry queue, so up to two samples wait while the
//   back end works and a finished result sits in the output register.
// Stall: while out_chan.ready is low, hold the result; the back end holds its next result
//   and the queue fills, after which in_chan.ready drops.
// Reset (rst_n low, synchronous): queue empties, output valid drops, the pitch estimate
//   clears to zero and the config registers return to 0.98, 0.02 s and 0.205 rad.
module tilt_complementary_filter
  import tcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tcf_in_if.sink               in_chan,
  tcf_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  tcf_cfg_t   cfg_r;
  tcf_qstat_t qstat;
  tcf_job_t   front_job;
  tcf_job_t   head_job;
  logic       push;
  logic       pop;

  // Configuration registers; unknown indexes fall through untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_weight  <= BLEND_WEIGHT_RST;
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.angle_offset  <= ANGLE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_WEIGHT:  cfg_r.blend_weight  <= cfg_wdata;
        CFG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_wdata;
        CFG_ANGLE_OFFSET:  cfg_r.angle_offset  <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Accept and classify requests.
  tcf_front u_front (
    .in_chan (in_chan),
    .qstat   (qstat),
    .push    (push),
    .job     (front_job)
  );

  // Buffer classified jobs so each side can stall independently.
  tcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (front_job),
    .pop     (pop),
    .job_out (head_job),
    .qstat   (qstat)
  );

  // Run CORDIC and the blend, then drive the result register.
  tcf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .qstat    (qstat),
    .job_in   (head_job),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

/* rtl/tcf_checker.sv */
// Port-level checker for the tilt complementary filter and its bind.
module tcf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic [2:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without an accepted request");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == 3'd4) |-> !in_ready)
    else $error("request taken with queue, back end and output all occupied");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);

/* tb/tilt_complementary_filter_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the tilt complementary filter: pitch pairs predicted per request.
module tilt_complementary_filter_test;
  import tcf_pkg::*;

  // Index with no register behind it; writes to it must leave the block alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_PHASES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the job queue
  localparam int MAX_GAP         = 40;    // cap on one sender idle stretch
  localparam int DRAIN_CYCLES    = 40;    // wait after the drain for stray results
  localparam int PRINT_LIMIT     = 100;

  typedef struct {
    logic signed [15:0] measured;
    logic signed [15:0] filtered;
  } pitch_pair_t;

  // Keeps its own copy of the configuration and the pitch estimate, predicts the
  // pitch pair of every accepted request and checks results in order.
  class pitch_tracker;
    longint             atan_units [ATAN_N];
    longint             alpha;
    longint             dt_q16;
    longint             offset;
    logic signed [15:0] estimate;
    pitch_pair_t        expected_pitch [$];
    int                 mismatches;

    function new();
      atan_units = '{13176795, 7778716, 4110060, 2086331, 1047214,
                     524117, 262123, 131069, 65536, 32768,
                     16384, 8192, 4096, 2048, 1024,
                     512, 256, 128, 64, 32};
      alpha      = BLEND_WEIGHT_RST;
      dt_q16     = SAMPLE_PERIOD_RST;
      offset     = ANGLE_OFFSET_RST;
      estimate   = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_BLEND_WEIGHT:  alpha  = longint'(data);
        CFG_SAMPLE_PERIOD: dt_q16 = longint'(data);
        CFG_ANGLE_OFFSET:  offset = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    // atan2(z, x) in units of 2^-24 rad, vectoring rotations
    function longint pitch_units(longint x, longint z);
      longint vx, vy, acc, dx, dy;
      acc = 0;
      if (x == 0 && z == 0) return 0;
      vx = x * 65536;
      vy = z * 65536;
      // Left half plane: turn by pi first
      if (x < 0) begin
        acc = (z >= 0) ? 64'sd52707179 : -64'sd52707179;
        vx  = -vx;
        vy  = -vy;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx  += dx;
          vy  -= dy;
          acc += atan_units[i];
        end else begin
          vx  -= dx;
          vy  += dy;
          acc -= atan_units[i];
        end
      end
      return acc;
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] az,
                              logic signed [15:0] rate);
      longint      ang, pred, blend;
      pitch_pair_t p;
      ang        = pitch_units(ax, az);
      p.measured = clamp16(((ang + 1024) >>> 11) - offset);
      pred       = longint'(estimate) * 8192 + longint'(rate) * dt_q16;
      blend      = (65536 - alpha) * (longint'(p.measured) * 8192) + alpha * pred;
      p.filtered = clamp16((blend + (longint'(1) <<< 28)) >>> 29);
      estimate   = p.filtered;
      expected_pitch.push_back(p);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic signed [15:0] meas, logic signed [15:0] filt);
      pitch_pair_t p;
      if (expected_pitch.size() == 0) begin
        flag_mismatch($sformatf("result %0d/%0d with no request waiting", meas, filt));
        return;
      end
      p = expected_pitch.pop_front();
      if (meas !== p.measured)
        flag_mismatch($sformatf("measured_angle %0d, want %0d", meas, p.measured));
      if (filt !== p.filtered)
        flag_mismatch($sformatf("filtered_angle %0d, want %0d", filt, p.filtered));
    endtask

    function int pending();
      return expected_pitch.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;

  // Idle odds in percent per cycle; stall_pct is read by the receiver process.
  int idle_pct      = 0;
  int stall_pct     = 0;
  // Bump hold_off_req to ask the receiver for one long hold-off.
  int hold_off_req  = 0;
  int hold_off_seen = 0;

  pitch_tracker tracker = new();

  tcf_in_if  in_chan ();
  tcf_out_if out_chan ();

  tilt_complementary_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Offer one request, idling first at the phase's odds; return once it is taken.
  // Entered and left right after a rising edge, so every drive lands on the edge.
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                             input logic signed [15:0] rate);
    int gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.accel_x <= ax;
    in_chan.accel_z <= az;
    in_chan.rate_y  <= rate;
    // Values read right after the edge are the ones the block saw at that edge
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tracker.note_sample(ax, az, rate);
  endtask

  // Drop valid and hold until every predicted pitch pair has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Leaves cfg_we high; the caller drops it after its last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  // Drain the block, then write all three registers.
  task automatic load_config(input logic [15:0] weight, input logic [15:0] period,
                             input logic [15:0] offset);
    wait_drained();
    write_register(CFG_BLEND_WEIGHT, weight);
    write_register(CFG_SAMPLE_PERIOD, period);
    write_register(CFG_ANGLE_OFFSET, offset);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Result side: check every accepted pitch pair against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tracker.check_result(out_chan.measured_angle, out_chan.filtered_angle);
    end
  end

  // Receiver: stall at the phase's odds, or hold off for a long stretch on request.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus: directed corners first, then random phases with varying config and idling.
  initial begin
    logic signed [15:0] ax, az, rate;
    int                 kind;
    in_chan.valid   = 1'b0;
    in_chan.accel_x = '0;
    in_chan.accel_z = '0;
    in_chan.rate_y  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config: zero vector, each quadrant, both axes, field extremes
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd16384, 16'sd0, 16'sd0);
    send_sample(-16'sd16384, 16'sd100, 16'sd50);
    send_sample(-16'sd16384, -16'sd100, -16'sd50);
    send_sample(16'sd0, 16'sd16384, 16'sd0);
    send_sample(16'sd0, -16'sd16384, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd0, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);

    // Alpha zero, most negative offset: measured saturates high near +pi
    load_config(16'd0, 16'hffff, 16'h8000);
    send_sample(-16'sd16384, 16'sd1, 16'sd0);
    send_sample(-16'sd16384, -16'sd1, 16'sd0);
    send_sample(16'sd32767, 16'sd0, -16'sd32768);

    // Full gyro weight and longest period: filtered saturates both ways,
    // largest offset pushes measured to its low rail
    load_config(16'hffff, 16'hffff, 16'h7fff);
    send_sample(-16'sd16384, -16'sd1, 16'sd32767);
    send_sample(-16'sd16384, -16'sd1, 16'sd32767);
    send_sample(-16'sd16384, -16'sd1, -16'sd32768);
    send_sample(16'sd0, 16'sd0, -16'sd32768);

    // Back to defaults, then a write to an unused index that must change nothing
    load_config(BLEND_WEIGHT_RST, SAMPLE_PERIOD_RST, ANGLE_OFFSET_RST);
    // Let the write enable drop for one cycle before the next write
    @(posedge clk);
    write_register(CFG_UNUSED, 16'hffff);
    cfg_we <= 1'b0;
    send_sample(16'sd1000, 16'sd2000, 16'sd300);
    send_sample(-16'sd1000, 16'sd2000, -16'sd300);
    send_sample(16'sd12345, -16'sd23456, 16'sd1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      int wgt, per, off, count;
      wgt   = $urandom_range(65535);
      per   = $urandom_range(65535);
      off   = int'($urandom_range(65535)) - 32768;
      count = 250;
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct <= 0;
          wgt = BLEND_WEIGHT_RST; per = SAMPLE_PERIOD_RST; off = ANGLE_OFFSET_RST;
        end
        1: begin
          idle_pct = 50; stall_pct <= 0;
          wgt = 32768; per = 65535; off = 0;
        end
        2: begin
          idle_pct = 0;  stall_pct <= 50;
          wgt = 0; per = 0; off = -32768; count = 200;
        end
        3: begin
          idle_pct = 9;  stall_pct <= 9;
          wgt = 65535; per = 1; off = 32767; count = 200;
        end
        4: begin
          idle_pct = 0;  stall_pct <= 0;
        end
        5: begin
          idle_pct = 50; stall_pct <= 0;
        end
        6: begin
          idle_pct = 0;  stall_pct <= 50;
          wgt = BLEND_WEIGHT_RST; per = SAMPLE_PERIOD_RST; off = ANGLE_OFFSET_RST;
        end
        default: begin
          idle_pct = 9;  stall_pct <= 9; count = 200;
        end
      endcase
      load_config(16'(wgt), 16'(per), 16'(off));

      for (int k = 0; k < count; k++) begin
        // Hold off the receiver while requests keep coming, so the queue backs up
        if (ph == 4 && k == 20) hold_off_req <= hold_off_req + 1;
        // Pause the sender until the block is empty, mid-phase
        if (ph == 5 && k == count / 2) wait_drained();
        kind = $urandom_range(9);
        case (kind)
          0, 1, 2, 3: begin
            ax   = 16'($urandom);
            az   = 16'($urandom);
            rate = 16'($urandom);
          end
          4, 5, 6: begin
            // Plausible IMU readings: moderate tilt, slow rate
            ax   = 16'(int'($urandom_range(40000)) - 20000);
            az   = 16'(int'($urandom_range(40000)) - 20000);
            rate = 16'(int'($urandom_range(4000)) - 2000);
          end
          7: begin
            // One axis zero; now and then both
            if ($urandom_range(1) == 1) begin
              ax = 16'sd0;
              az = 16'($urandom);
            end else begin
              ax = 16'($urandom);
              az = 16'sd0;
            end
            if ($urandom_range(9) == 0) az = 16'sd0;
            rate = 16'(int'($urandom_range(2000)) - 1000);
          end
          default: begin
            ax   = corner_value();
            az   = corner_value();
            rate = corner_value();
          end
        endcase
        send_sample(ax, az, rate);
      end
    end

    // Drain, then give any stray result time to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* tilt_complementary_filter.f */
rtl/tcf_pkg.sv
rtl/tcf_if.sv
rtl/tcf_front.sv
rtl/tcf_queue.sv
rtl/tcf_back.sv
rtl/tilt_complementary_filter.sv
rtl/tcf_checker.sv
tb/tilt_complementary_filter_test.sv
